// ===== rtl/ppsch_pkg.sv =====
package ppsch_pkg;

   // Table size and derived widths
   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam idx_type LAST_IDX = idx_type'(MAX_PROCS - 1);
   localparam cnt_type MAX_CNT  = cnt_type'(MAX_PROCS);

   // Request operations
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_SUM  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  process_id;
      logic [15:0] arrive_at;
      logic [15:0] service_len;
      logic [15:0] priority_req;
   } req_type;

   typedef struct packed {
      logic        load_accepted;
      logic        ran_valid;
      logic [7:0]  ran_pid;
      logic [15:0] tick_time;
      logic        finished;
      logic [15:0] finish_wait;
      logic [15:0] finish_turnaround;
      logic        all_finished;
      logic [31:0] wait_total;
      logic [31:0] turnaround_total;
   } rsp_type;

   // Entry write broadcast from the controller
   typedef struct packed {
      logic        en;
      idx_type     idx;
      logic [7:0]  pid;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] prio;
   } wr_type;

   // Decrement broadcast for the selected entry
   typedef struct packed {
      logic    en;
      idx_type idx;
   } run_type;

   // Best-so-far candidate passed down the cell row
   typedef struct packed {
      logic        found;
      idx_type     idx;
      logic [7:0]  pid;
      logic [15:0] prio;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
   } tok_type;

endpackage

// ===== rtl/ppsch_cell.sv =====
module ppsch_cell (
   input  logic               clock,
   input  logic               reset,
   input  ppsch_pkg::idx_type cell_idx,
   input  logic [15:0]        cur_time,
   input  ppsch_pkg::wr_type  wr,
   input  ppsch_pkg::run_type run,
   input  ppsch_pkg::tok_type tok_in,
   output ppsch_pkg::tok_type tok_out
);

   logic               valid_ff;
   logic [7:0]         pid_ff;
   logic [15:0]        arrival_ff;
   logic [15:0]        burst_ff;
   logic [15:0]        remaining_ff;
   logic [15:0]        prio_ff;
   ppsch_pkg::tok_type tok_ff;
   ppsch_pkg::tok_type tok_in_sel;
   logic               eligible;
   logic               better;

   // Valid bit: set on write into this slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && wr.idx == cell_idx) begin
         valid_ff <= 1'b1;
      end
   end

   // Hold the entry; count down remaining service when selected
   always_ff @(posedge clock) begin
      if (wr.en && wr.idx == cell_idx) begin
         pid_ff       <= wr.pid;
         arrival_ff   <= wr.arrival;
         burst_ff     <= wr.burst;
         remaining_ff <= wr.burst;
         prio_ff      <= wr.prio;
      end else if (run.en && run.idx == cell_idx) begin
         remaining_ff <= remaining_ff - 16'd1;
      end
   end

   // Replace the incoming candidate only when strictly better
   always_comb begin
      eligible = valid_ff && (remaining_ff != 16'd0) && (arrival_ff <= cur_time);
      better   = !tok_in.found || (prio_ff < tok_in.prio) ||
                 ((prio_ff == tok_in.prio) && (arrival_ff < tok_in.arrival));
      tok_in_sel = tok_in;
      if (eligible && better) begin
         tok_in_sel.found     = 1'b1;
         tok_in_sel.idx       = cell_idx;
         tok_in_sel.pid       = pid_ff;
         tok_in_sel.prio      = prio_ff;
         tok_in_sel.arrival   = arrival_ff;
         tok_in_sel.burst     = burst_ff;
         tok_in_sel.remaining = remaining_ff;
      end
   end

   // Advance the candidate to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_sel;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_data (ppsch_pkg::req_type)
// rsp      out        rsp_valid/rsp_ready  rsp_data (ppsch_pkg::rsp_type)
//
// A load goes from IDLE straight to RESP, where its result is parked in the
// output register. A tick walks the best candidate down the row of entry
// cells, one cell per cycle, in SCAN, then selects in EVAL and sums in SUM.
// One request is in work at a time; the next is accepted the cycle after the
// result is parked in the output register. A stalled rsp holds the block in
// RESP.
// Synchronous reset empties the table and clears time and sums.
module preemptive_priority_scheduler_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ppsch_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ppsch_pkg::rsp_type rsp_data
);

   ppsch_pkg::state_type state_ff, state_in;
   ppsch_pkg::idx_type   scan_cnt_ff;
   ppsch_pkg::cnt_type   loaded_count_ff;
   ppsch_pkg::cnt_type   finished_count_ff;
   logic [15:0]          current_time_ff;
   logic [31:0]          wait_sum_ff;
   logic [31:0]          turnaround_sum_ff;

   logic                 res_load_ff;
   logic                 res_ran_ff;
   logic [7:0]           res_pid_ff;
   logic [15:0]          res_time_ff;
   logic                 res_fin_ff;
   logic [15:0]          res_wait_ff;
   logic [15:0]          res_turn_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   ppsch_pkg::rsp_type   rsp_ff;

   ppsch_pkg::wr_type    wr;
   ppsch_pkg::run_type   run;
   ppsch_pkg::tok_type   tok_chain [ppsch_pkg::MAX_PROCS+1];
   ppsch_pkg::tok_type   best;

   logic                 req_fire;
   logic                 push;
   logic                 finish_now;
   logic [16:0]          end17;
   logic [16:0]          turn17;
   logic [16:0]          need17;
   logic [16:0]          wait17;
   logic [15:0]          turn16;
   logic [15:0]          wait16;
   logic [32:0]          wsum33;
   logic [32:0]          tsum33;

   assign req_ready = (state_ff == ppsch_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Broadcast a load into the next free slot
   always_comb begin
      wr.en      = req_fire && (req_data.opcode == ppsch_pkg::OP_LOAD) &&
                   (loaded_count_ff < ppsch_pkg::MAX_CNT);
      wr.idx     = loaded_count_ff[ppsch_pkg::IDX_W-1:0];
      wr.pid     = req_data.process_id;
      wr.arrival = req_data.arrive_at;
      wr.burst   = (req_data.service_len == 16'd0) ? 16'd1 : req_data.service_len;
      wr.prio    = req_data.priority_req;
   end

   // Row of entry cells
   assign tok_chain[0] = '0;

   for (genvar i = 0; i < ppsch_pkg::MAX_PROCS; i++) begin : g_cell
      ppsch_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (ppsch_pkg::idx_type'(i)),
         .cur_time (current_time_ff),
         .wr       (wr),
         .run      (run),
         .tok_in   (tok_chain[i]),
         .tok_out  (tok_chain[i+1])
      );
   end

   assign best = tok_chain[ppsch_pkg::MAX_PROCS];

   // Selected entry runs one unit
   always_comb begin
      run.en     = (state_ff == ppsch_pkg::ST_EVAL) && best.found;
      run.idx    = best.idx;
      finish_now = run.en && (best.remaining == 16'd1);
   end

   // Completion times, saturated to 16 bits
   always_comb begin
      end17  = {1'b0, current_time_ff} + 17'd1;
      turn17 = end17 - {1'b0, best.arrival};
      need17 = {1'b0, best.arrival} + {1'b0, best.burst};
      wait17 = (end17 > need17) ? (end17 - need17) : 17'd0;
      turn16 = turn17[16] ? 16'hFFFF : turn17[15:0];
      wait16 = wait17[16] ? 16'hFFFF : wait17[15:0];
   end

   // Saturating sums
   always_comb begin
      wsum33 = {1'b0, wait_sum_ff} + {17'd0, res_wait_ff};
      tsum33 = {1'b0, turnaround_sum_ff} + {17'd0, res_turn_ff};
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppsch_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.opcode == ppsch_pkg::OP_TICK) ?
                          ppsch_pkg::ST_SCAN : ppsch_pkg::ST_RESP;
            end
         end
         ppsch_pkg::ST_SCAN: begin
            if (scan_cnt_ff == ppsch_pkg::LAST_IDX) begin
               state_in = ppsch_pkg::ST_EVAL;
            end
         end
         ppsch_pkg::ST_EVAL: state_in = ppsch_pkg::ST_SUM;
         ppsch_pkg::ST_SUM:  state_in = ppsch_pkg::ST_RESP;
         ppsch_pkg::ST_RESP: begin
            if (push) begin
               state_in = ppsch_pkg::ST_IDLE;
            end
         end
         default: state_in = ppsch_pkg::ST_IDLE;
      endcase
   end

   // Control state, counters, time and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ppsch_pkg::ST_IDLE;
         scan_cnt_ff       <= '0;
         loaded_count_ff   <= '0;
         finished_count_ff <= '0;
         current_time_ff   <= '0;
         wait_sum_ff       <= '0;
         turnaround_sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ppsch_pkg::ST_SCAN) begin
            scan_cnt_ff <= scan_cnt_ff + ppsch_pkg::idx_type'(1);
         end else begin
            scan_cnt_ff <= '0;
         end
         if (wr.en) begin
            loaded_count_ff <= loaded_count_ff + ppsch_pkg::cnt_type'(1);
         end
         if (finish_now) begin
            finished_count_ff <= finished_count_ff + ppsch_pkg::cnt_type'(1);
         end
         if (state_ff == ppsch_pkg::ST_EVAL && current_time_ff != 16'hFFFF) begin
            current_time_ff <= current_time_ff + 16'd1;
         end
         if (state_ff == ppsch_pkg::ST_SUM) begin
            wait_sum_ff       <= wsum33[32] ? 32'hFFFF_FFFF : wsum33[31:0];
            turnaround_sum_ff <= tsum33[32] ? 32'hFFFF_FFFF : tsum33[31:0];
         end
      end
   end

   // Collect per-request result fields
   always_ff @(posedge clock) begin
      if (req_fire) begin
         res_load_ff <= wr.en;
         res_ran_ff  <= 1'b0;
         res_pid_ff  <= 8'd0;
         res_time_ff <= 16'd0;
         res_fin_ff  <= 1'b0;
         res_wait_ff <= 16'd0;
         res_turn_ff <= 16'd0;
      end else if (state_ff == ppsch_pkg::ST_EVAL) begin
         res_ran_ff  <= best.found;
         res_pid_ff  <= best.found ? best.pid : 8'd0;
         res_time_ff <= current_time_ff;
         res_fin_ff  <= finish_now;
         res_wait_ff <= finish_now ? wait16 : 16'd0;
         res_turn_ff <= finish_now ? turn16 : 16'd0;
      end
   end

   // Output register: load when empty or drained this cycle
   assign push = (state_ff == ppsch_pkg::ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff.load_accepted     <= res_load_ff;
         rsp_ff.ran_valid         <= res_ran_ff;
         rsp_ff.ran_pid           <= res_pid_ff;
         rsp_ff.tick_time         <= res_time_ff;
         rsp_ff.finished          <= res_fin_ff;
         rsp_ff.finish_wait       <= res_wait_ff;
         rsp_ff.finish_turnaround <= res_turn_ff;
         rsp_ff.all_finished      <= (finished_count_ff == loaded_count_ff);
         rsp_ff.wait_total        <= wait_sum_ff;
         rsp_ff.turnaround_total  <= turnaround_sum_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Completions never outnumber loads
   a_fin_le_load: assert property (@(posedge clock) disable iff (reset)
      finished_count_ff <= loaded_count_ff)
      else $error("finished count exceeds loaded count");

   // An accepted load with room grows the table by one
   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.opcode == ppsch_pkg::OP_LOAD &&
       loaded_count_ff < ppsch_pkg::MAX_CNT)
      |=> loaded_count_ff == $past(loaded_count_ff) + ppsch_pkg::cnt_type'(1))
      else $error("load did not take a slot");

   // The selected entry has arrived and still needs service
   a_winner_ok: assert property (@(posedge clock) disable iff (reset)
      run.en |-> (best.arrival <= current_time_ff && best.remaining != 16'd0))
      else $error("ineligible entry selected");

   // Time moves only during tick evaluation, by one unit or held at the top
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ppsch_pkg::ST_EVAL) |=> $stable(current_time_ff))
      else $error("time moved outside tick evaluation");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 500;
   localparam int DRAIN_CYCLES   = ppsch_pkg::MAX_PROCS + 12;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   ppsch_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   ppsch_pkg::rsp_type rsp_data;

   preemptive_priority_scheduler_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Shadow process table and scheduler state
   logic [15:0] tbl_arrival [ppsch_pkg::MAX_PROCS];
   logic [15:0] tbl_left    [ppsch_pkg::MAX_PROCS];
   logic [15:0] tbl_burst   [ppsch_pkg::MAX_PROCS];
   logic [15:0] tbl_prio    [ppsch_pkg::MAX_PROCS];
   logic [7:0]  tbl_pid     [ppsch_pkg::MAX_PROCS];
   int unsigned n_loaded   = 0;
   int unsigned n_done     = 0;
   logic [15:0] now_time   = '0;
   logic [31:0] wait_acc   = '0;
   logic [31:0] turn_acc   = '0;

   // Outcomes still owed by the block, oldest first
   ppsch_pkg::rsp_type pending_outcomes[$];
   ppsch_pkg::rsp_type want_rsp;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_off_req  = 1'b0;

   int mismatches   = 0;
   int rsp_seen     = 0;
   int loads_stored = 0;
   int loads_refused = 0;
   int ticks_busy   = 0;
   int ticks_idle   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow state and return the outcome it causes
   function automatic ppsch_pkg::rsp_type advance_schedule(input ppsch_pkg::req_type r);
      ppsch_pkg::rsp_type o;
      int          best;
      bit          found;
      logic [16:0] end_t;
      logic [16:0] need;
      logic [16:0] turn17;
      logic [16:0] wait17;
      logic [32:0] sum;
      o = '0;
      if (r.opcode == ppsch_pkg::OP_LOAD) begin
         if (n_loaded < ppsch_pkg::MAX_PROCS) begin
            tbl_pid[n_loaded]     = r.process_id;
            tbl_arrival[n_loaded] = r.arrive_at;
            tbl_burst[n_loaded]   = (r.service_len == 16'd0) ? 16'd1 : r.service_len;
            tbl_left[n_loaded]    = tbl_burst[n_loaded];
            tbl_prio[n_loaded]    = r.priority_req;
            n_loaded++;
            o.load_accepted = 1'b1;
         end
      end else begin
         found = 1'b0;
         best  = 0;
         // pick lowest priority number, then earlier arrival, then earlier load
         for (int i = 0; i < n_loaded; i++) begin
            if (tbl_left[i] != 16'd0 && tbl_arrival[i] <= now_time) begin
               if (!found || tbl_prio[i] < tbl_prio[best] ||
                   (tbl_prio[i] == tbl_prio[best] && tbl_arrival[i] < tbl_arrival[best])) begin
                  best  = i;
                  found = 1'b1;
               end
            end
         end
         o.tick_time = now_time;
         if (found) begin
            o.ran_valid = 1'b1;
            o.ran_pid   = tbl_pid[best];
            tbl_left[best]--;
            if (tbl_left[best] == 16'd0) begin
               end_t  = {1'b0, now_time} + 17'd1;
               need   = {1'b0, tbl_arrival[best]} + {1'b0, tbl_burst[best]};
               turn17 = end_t - {1'b0, tbl_arrival[best]};
               wait17 = (end_t > need) ? end_t - need : 17'd0;
               if (turn17 > 17'hFFFF) turn17 = 17'hFFFF;
               if (wait17 > 17'hFFFF) wait17 = 17'hFFFF;
               n_done++;
               sum      = {1'b0, wait_acc} + 33'(wait17);
               wait_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               sum      = {1'b0, turn_acc} + 33'(turn17);
               turn_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               o.finished          = 1'b1;
               o.finish_wait       = wait17[15:0];
               o.finish_turnaround = turn17[15:0];
            end
         end
         if (now_time != 16'hFFFF) now_time++;
      end
      o.all_finished     = (n_done == n_loaded);
      o.wait_total       = wait_acc;
      o.turnaround_total = turn_acc;
      return o;
   endfunction

   function automatic ppsch_pkg::req_type make_load(input logic [7:0] pid,
                                                    input logic [15:0] arr,
                                                    input logic [15:0] burst,
                                                    input logic [15:0] prio);
      ppsch_pkg::req_type r;
      r.opcode       = ppsch_pkg::OP_LOAD;
      r.process_id   = pid;
      r.arrive_at    = arr;
      r.service_len  = burst;
      r.priority_req = prio;
      return r;
   endfunction

   // Tick with junk in the unused fields
   function automatic ppsch_pkg::req_type make_tick();
      ppsch_pkg::req_type r;
      r = make_load(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      r.opcode = ppsch_pkg::OP_TICK;
      return r;
   endfunction

   // Load a process that arrives at or before the current time or up to 60 units after it, with frequent ties
   function automatic ppsch_pkg::req_type random_process();
      logic [15:0] arr;
      logic [15:0] prio;
      case ($urandom_range(0, 3))
         0: arr = now_time;
         1: arr = now_time + 16'($urandom_range(1, 60));
         2: arr = 16'($urandom_range(0, now_time));
         default: arr = now_time + 16'($urandom_range(0, 3) * 8);
      endcase
      prio = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      return make_load(8'($urandom), arr, 16'($urandom_range(20, 200)), prio);
   endfunction

   // Offer one request, hold it until accepted, then log its outcome
   task automatic send_request(input ppsch_pkg::req_type r);
      ppsch_pkg::rsp_type outcome;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      outcome = advance_schedule(r);
      pending_outcomes.push_back(outcome);
      if (r.opcode == ppsch_pkg::OP_LOAD) begin
         if (outcome.load_accepted) loads_stored++;
         else loads_refused++;
      end else begin
         if (outcome.ran_valid) ticks_busy++;
         else ticks_idle++;
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in response %0d, %s: expected %0d, got %0d",
                     rsp_seen, field, want, got);
      end
   endtask

   // Compare each accepted response with the oldest outcome owed
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response %0d arrived with none owed", rsp_seen);
         end else begin
            want_rsp = pending_outcomes.pop_front();
            check_field("load_accepted", want_rsp.load_accepted, rsp_data.load_accepted);
            check_field("ran_valid", want_rsp.ran_valid, rsp_data.ran_valid);
            check_field("ran_pid", want_rsp.ran_pid, rsp_data.ran_pid);
            check_field("tick_time", want_rsp.tick_time, rsp_data.tick_time);
            check_field("finished", want_rsp.finished, rsp_data.finished);
            check_field("finish_wait", want_rsp.finish_wait, rsp_data.finish_wait);
            check_field("finish_turnaround", want_rsp.finish_turnaround,
                        rsp_data.finish_turnaround);
            check_field("all_finished", want_rsp.all_finished, rsp_data.all_finished);
            check_field("wait_total", want_rsp.wait_total, rsp_data.wait_total);
            check_field("turnaround_total", want_rsp.turnaround_total,
                        rsp_data.turnaround_total);
         end
         rsp_seen++;
      end
   end

   // End the run when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("no request or response moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Idle tick on an empty table, tie breaks, zero burst, preemption
   task automatic test_directed_schedule();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(make_tick());
      send_request(make_load(8'hFF, 16'd2, 16'd0, 16'd4));
      send_request(make_load(8'h00, 16'd2, 16'd3, 16'd4));
      send_request(make_load(8'h11, 16'd1, 16'd1, 16'd4));
      send_request(make_load(8'h22, 16'd4, 16'd2, 16'd0));
      repeat (7) send_request(make_tick());
      send_request(make_load(8'h5A, 16'd7, 16'd1, 16'hFFFF));
      repeat (2) send_request(make_tick());
   endtask

   // Mostly ticks with a few process loads spread through the phase
   task automatic run_random_traffic(input int items, input int quota,
                                     input int idle_pct, input int stall_pct);
      int stored;
      stored        = 0;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < items; k++) begin
         if (stored < quota && $urandom_range(0, 99) < 3) begin
            send_request(random_process());
            stored++;
         end else begin
            send_request(make_tick());
         end
      end
   endtask

   // Hold responses off while requests keep coming so the input stalls
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_req  = 1'b1;
      repeat (12) send_request(make_tick());
   endtask

   // Fill the table, try refused loads, then run until every process completes
   task automatic test_full_table();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // low-priority background job and a short urgent job that arrives later
      send_request(make_load(8'hA5, 16'h0000, 16'd60, 16'hFFFF));
      send_request(make_load(8'h5A, now_time + 16'd40, 16'd2, 16'h0000));
      while (n_loaded < ppsch_pkg::MAX_PROCS) send_request(random_process());
      send_request(make_load(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_request(make_load(8'h00, 16'h0000, 16'h0000, 16'h0000));
      repeat (20) send_request(make_load(8'($urandom), 16'($urandom), 16'($urandom),
                                         16'($urandom)));
      while (n_done != n_loaded) send_request(make_tick());
      repeat (4) send_request(make_tick());
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_schedule();
      run_random_traffic(300, 3, 0, 0);
      run_random_traffic(300, 2, 84, 0);
      run_random_traffic(300, 2, 0, 84);
      run_random_traffic(300, 2, 26, 26);
      test_output_hold_off();
      test_full_table();
      req_valid <= 1'b0;

      // wait for every owed response, then let the block settle
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d stored loads, %0d refused loads, %0d busy and %0d idle ticks",
               loads_stored, loads_refused, ticks_busy, ticks_idle);
      $display("%0d processes completed, time reached %0d, %0d responses checked",
               n_done, now_time, rsp_seen);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
